>>> sv/windowed_stddev_motion_gate_defines.svh
// assertion macros for the windowed stddev motion gate
`ifndef WINDOWED_STDDEV_MOTION_GATE_DEFINES_SVH
`define WINDOWED_STDDEV_MOTION_GATE_DEFINES_SVH
// implication checked on every rising edge outside reset
`define WSMG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsmg check failed");
// next-cycle implication checked outside reset
`define WSMG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsmg check failed");
`endif

>>> sv/wsmg_pkg.sv
// package: widths, constants and word types of the motion gate
`timescale 1ns / 1ps
package wsmg_pkg;
    localparam int WINDOW_SAMPLES = 20;
    localparam int IDX_W = $clog2(WINDOW_SAMPLES);
    localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
    localparam logic [15:0] ACCEPT_LOW = 16'd820;
    localparam logic [15:0] ACCEPT_HIGH = 16'd32768;
    localparam logic [15:0] VALID_LOW = 16'd820;
    localparam logic [15:0] VALID_HIGH = 16'd20479;
    localparam logic [CNT_W-1:0] MIN_HELD = CNT_W'(6);
    localparam logic [CNT_W-1:0] MIN_VALID = CNT_W'(5);
    // sum of up to WINDOW_SAMPLES samples and of their squared deviations
    localparam int SUM_W = 16 + $clog2(WINDOW_SAMPLES + 1);
    localparam int SQ_W = 32 + $clog2(WINDOW_SAMPLES + 1);
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;
    localparam logic [2:0] REG_STDDEV_THR = 3'd0;
    localparam logic [2:0] REG_P2P_THR = 3'd1;
    localparam logic [2:0] REG_ON_DELAY = 3'd2;
    localparam logic [2:0] REG_OFF_DELAY = 3'd3;
    localparam logic [2:0] REG_GAP_TOL = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [15:0] sample_g;
        logic [31:0] timestamp_ms;
    } in_word_t;

    typedef struct packed {
        logic        gate_on;
        logic        motion_now;
        logic        sample_taken;
        logic [15:0] stddev_g;
        logic [15:0] p2p_g;
    } out_word_t;
endpackage

>>> sv/wsmg_ram.sv
// generic simple dual-port ram (one write port, one read port) with registered read
`timescale 1ns / 1ps
module wsmg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/windowed_stddev_motion_gate.sv
// top level: windowed stddev motion gate with hysteresis timers
// a clear or rejected word goes straight to the result; with fewer than six held or five valid
//   entries the metrics are skipped, else the full metrics run passes, divides, bit-pair root
// throughput: one word at a time; the next word is taken the cycle after the result handshake
// reset: rst_n asynchronous, clears window count, timers, gate and registers to defaults
// window ram has no reset; only written entries are ever read
`timescale 1ns / 1ps
module windowed_stddev_motion_gate (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wsmg_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output wsmg_pkg::out_word_t out_data
);
    import wsmg_pkg::*;

    localparam int DIV_W = SQ_W;
    localparam int DIVC_W = $clog2(DIV_W + 1);
    // root operand padded to an even width so bit pairs line up with the lsb
    localparam int RV_W = SQ_W + SQ_W % 2;
    localparam int RT_W = SQ_W / 2 + 1;
    localparam int RTC_W = $clog2(RT_W + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_P1 = 4'd1;
    localparam logic [3:0] ST_DIV1 = 4'd2;
    localparam logic [3:0] ST_P2 = 4'd3;
    localparam logic [3:0] ST_DIV2 = 4'd4;
    localparam logic [3:0] ST_SQRT = 4'd5;
    localparam logic [3:0] ST_DEC = 4'd6;
    localparam logic [3:0] ST_OUT = 4'd7;
    localparam logic [3:0] ST_SQ = 4'd8;

    // configuration registers
    logic [15:0] stddev_thr_reg, p2p_thr_reg, on_delay_reg, off_delay_reg, gap_tol_reg;
    logic        cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stddev_thr_reg <= 16'd225;
            p2p_thr_reg    <= 16'd492;
            on_delay_reg   <= 16'd180;
            off_delay_reg  <= 16'd1200;
            gap_tol_reg    <= 16'd100;
        end
        else if (cfg_we && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[4:2])
                REG_STDDEV_THR: stddev_thr_reg <= pwdata[15:0];
                REG_P2P_THR:    p2p_thr_reg    <= pwdata[15:0];
                REG_ON_DELAY:   on_delay_reg   <= pwdata[15:0];
                REG_OFF_DELAY:  off_delay_reg  <= pwdata[15:0];
                REG_GAP_TOL:    gap_tol_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (paddr[4:2])
                REG_STDDEV_THR: prdata = {16'd0, stddev_thr_reg};
                REG_P2P_THR:    prdata = {16'd0, p2p_thr_reg};
                REG_ON_DELAY:   prdata = {16'd0, on_delay_reg};
                REG_OFF_DELAY:  prdata = {16'd0, off_delay_reg};
                REG_GAP_TOL:    prdata = {16'd0, gap_tol_reg};
                default:        prdata = 32'd0;
            endcase
        end
    end

    // control state
    logic [3:0]       state_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [IDX_W-1:0] widx_reg;
    logic             gate_reg, mstart_reg, sstart_reg;
    logic [31:0]      msince_reg, ssince_reg;
    logic [15:0]      hstd_reg, hp2p_reg;
    logic             motion_reg, taken_reg;
    logic [31:0]      now_reg;
    // pass state
    logic [CNT_W-1:0] pidx_reg;
    logic             rd_v_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      mx_reg, mn_reg, mean_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [15:0]      dsq_reg;
    logic             dsq_v_reg;
    // shared restoring divider
    logic [DIV_W-1:0] dq_reg;
    logic [CNT_W:0]   drem_reg;
    logic [DIVC_W-1:0] dcnt_reg;
    // square root
    logic [RV_W-1:0]  rv_reg;
    logic [RT_W+1:0]  rrem_reg;
    logic [RT_W-1:0]  rroot_reg;
    logic [RTC_W-1:0] rcnt_reg;

    logic [15:0] rdata;
    logic        ram_we;
    logic [15:0] s_in;
    logic        accept_s;

    assign in_ready = (state_reg == ST_IDLE) && !out_valid;
    assign s_in = in_data.sample_g;
    assign accept_s = (s_in >= ACCEPT_LOW) && (s_in <= ACCEPT_HIGH);
    assign ram_we = in_valid && in_ready && in_data.cmd == CMD_SAMPLE && accept_s;

    wsmg_ram #(.WIDTH(16), .DEPTH(WINDOW_SAMPLES)) u_win (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg),
        .wdata (s_in),
        .raddr (pidx_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    logic        rd_ok;
    logic [15:0] dabs;
    logic [CNT_W:0] dtrial;
    logic [RT_W+1:0] rtrial;
    logic [31:0] dt_m, dt_s;
    assign rd_ok = rd_v_reg && rdata >= VALID_LOW && rdata <= VALID_HIGH;
    assign dabs = (rdata >= mean_reg) ? rdata - mean_reg : mean_reg - rdata;
    assign dtrial = {drem_reg[CNT_W-1:0], dq_reg[DIV_W-1]};
    assign rtrial = {rrem_reg[RT_W-1:0], rv_reg[RV_W-1 -: 2]};
    assign dt_m = now_reg - msince_reg;
    assign dt_s = now_reg - ssince_reg;

    logic [RT_W+1:0] rsub;
    assign rsub = {rroot_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            out_valid  <= 1'b0;
            fill_reg   <= '0;
            widx_reg   <= '0;
            gate_reg   <= 1'b0;
            mstart_reg <= 1'b0;
            sstart_reg <= 1'b0;
            msince_reg <= '0;
            ssince_reg <= '0;
            hstd_reg   <= '0;
            hp2p_reg   <= '0;
            rd_v_reg   <= 1'b0;
            dsq_v_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        motion_reg <= 1'b0;
                        taken_reg  <= (in_data.cmd == CMD_SAMPLE) && accept_s;
                        now_reg    <= in_data.timestamp_ms;
                        if (in_data.cmd == CMD_CLEAR)
                        begin
                            fill_reg <= '0; widx_reg <= '0; gate_reg <= 1'b0;
                            mstart_reg <= 1'b0; sstart_reg <= 1'b0;
                            msince_reg <= '0; ssince_reg <= '0;
                            hstd_reg <= '0; hp2p_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                        else if (accept_s)
                        begin
                            widx_reg <= (widx_reg == IDX_W'(WINDOW_SAMPLES - 1)) ?
                                        '0 : widx_reg + 1'b1;
                            if (fill_reg < CNT_W'(WINDOW_SAMPLES))
                            begin
                                fill_reg <= fill_reg + 1'b1;
                            end
                            pidx_reg <= '0;
                            sum_reg <= '0; cnt_reg <= '0;
                            mx_reg <= '0; mn_reg <= 16'hFFFF;
                            state_reg <= ST_P1;
                        end
                        else
                        begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                // first pass: sum, count, max, min
                ST_P1:
                begin
                    if (fill_reg < MIN_HELD)
                    begin
                        state_reg <= ST_DEC;
                    end
                    else
                    begin
                        rd_v_reg <= (pidx_reg < fill_reg);
                        if (pidx_reg < fill_reg) pidx_reg <= pidx_reg + 1'b1;
                        if (rd_ok)
                        begin
                            sum_reg <= sum_reg + SUM_W'(rdata);
                            cnt_reg <= cnt_reg + 1'b1;
                            if (rdata > mx_reg) mx_reg <= rdata;
                            if (rdata < mn_reg) mn_reg <= rdata;
                        end
                        if (!rd_v_reg && pidx_reg == fill_reg && pidx_reg != '0)
                        begin
                            dq_reg <= DIV_W'(sum_reg);
                            drem_reg <= '0;
                            dcnt_reg <= DIVC_W'(DIV_W);
                            state_reg <= ST_DIV1;
                        end
                    end
                end
                // restoring divide, one quotient bit a cycle, also used for variance
                ST_DIV1, ST_DIV2:
                begin
                    if (cnt_reg < MIN_VALID)
                    begin
                        state_reg <= ST_DEC;
                    end
                    else if (dcnt_reg != '0)
                    begin
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (dtrial >= {1'b0, cnt_reg})
                        begin
                            drem_reg <= dtrial - {1'b0, cnt_reg};
                            dq_reg <= {dq_reg[DIV_W-2:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= dtrial;
                            dq_reg <= {dq_reg[DIV_W-2:0], 1'b0};
                        end
                    end
                    else if (state_reg == ST_DIV1)
                    begin
                        mean_reg <= dq_reg[15:0];
                        pidx_reg <= '0;
                        sq_reg <= '0;
                        state_reg <= ST_P2;
                    end
                    else
                    begin
                        rv_reg <= RV_W'(dq_reg);
                        rrem_reg <= '0;
                        rroot_reg <= '0;
                        rcnt_reg <= RTC_W'(RV_W / 2);
                        state_reg <= ST_SQRT;
                    end
                end
                // second pass: read address held through ST_P2 and ST_SQ, deviation then square
                ST_P2:
                begin
                    rd_v_reg <= (pidx_reg < fill_reg);
                    dsq_reg <= dabs;
                    dsq_v_reg <= rd_ok;
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (dsq_v_reg)
                    begin
                        sq_reg <= sq_reg + SQ_W'(dsq_reg * dsq_reg);
                    end
                    dsq_v_reg <= 1'b0;
                    if (pidx_reg < fill_reg) pidx_reg <= pidx_reg + 1'b1;
                    if (pidx_reg == fill_reg && !rd_v_reg)
                    begin
                        dq_reg <= sq_reg + (dsq_v_reg ?
                                  SQ_W'(dsq_reg * dsq_reg) : '0);
                        drem_reg <= '0;
                        dcnt_reg <= DIVC_W'(DIV_W);
                        state_reg <= ST_DIV2;
                    end
                    else
                    begin
                        state_reg <= ST_P2;
                    end
                end
                // bit-pair integer square root
                ST_SQRT:
                begin
                    if (rcnt_reg != '0)
                    begin
                        rcnt_reg <= rcnt_reg - 1'b1;
                        rv_reg <= {rv_reg[RV_W-3:0], 2'b00};
                        if (rtrial >= rsub)
                        begin
                            rrem_reg <= rtrial - rsub;
                            rroot_reg <= {rroot_reg[RT_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rrem_reg <= rtrial;
                            rroot_reg <= {rroot_reg[RT_W-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        hstd_reg <= rroot_reg[15:0];
                        hp2p_reg <= mx_reg - mn_reg;
                        motion_reg <= rroot_reg[15:0] >= stddev_thr_reg &&
                                      (mx_reg - mn_reg) >= p2p_thr_reg;
                        state_reg <= ST_DEC;
                    end
                end
                // hysteresis timers
                ST_DEC:
                begin
                    state_reg <= ST_OUT;
                    if (motion_reg)
                    begin
                        sstart_reg <= 1'b0;
                        if (!mstart_reg)
                        begin
                            msince_reg <= now_reg;
                            mstart_reg <= 1'b1;
                            if (!gate_reg && on_delay_reg == 16'd0) gate_reg <= 1'b1;
                        end
                        else if (!gate_reg && dt_m >= {16'd0, on_delay_reg})
                        begin
                            gate_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        logic [31:0] ds;
                        ds = sstart_reg ? dt_s : 32'd0;
                        if (!sstart_reg)
                        begin
                            ssince_reg <= now_reg;
                            sstart_reg <= 1'b1;
                        end
                        if (!gate_reg && ds >= {16'd0, gap_tol_reg})
                            mstart_reg <= 1'b0;
                        if (gate_reg && ds >= {16'd0, off_delay_reg})
                        begin
                            gate_reg <= 1'b0;
                            mstart_reg <= 1'b0;
                        end
                    end
                end
                ST_OUT:
                begin
                    out_valid <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        out_data.gate_on      = gate_reg;
        out_data.motion_now   = motion_reg;
        out_data.sample_taken = taken_reg;
        out_data.stddev_g     = hstd_reg;
        out_data.p2p_g        = hp2p_reg;
    end
endmodule

>>> sv/wsmg_checker.sv
// port-level checker for the motion gate, bound to the top level
`timescale 1ns / 1ps
`include "windowed_stddev_motion_gate_defines.svh"
module wsmg_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input wsmg_pkg::in_word_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input wsmg_pkg::out_word_t out_data
);
    import wsmg_pkg::*;
    // after a taken clear word, out_valid is still low; its all-zero result comes later
    `WSMG_ASSERT_NEXT(a_clear_next, in_valid && in_ready && in_data.cmd == CMD_CLEAR, !out_valid)
    // no new word is taken while a result waits
    `WSMG_ASSERT_IMP(a_no_take_pending, out_valid, !in_ready)
    // motion is only reported for a taken sample
    `WSMG_ASSERT_IMP(a_motion_taken, out_valid && out_data.motion_now, out_data.sample_taken)
    // a pending result holds while stalled
    `WSMG_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind windowed_stddev_motion_gate wsmg_checker u_wsmg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> dv/tb_windowed_stddev_motion_gate.sv
// testbench for the windowed stddev motion gate: directed table, random bursts, scoreboard
`timescale 1ns / 1ps
module tb_windowed_stddev_motion_gate;
    import wsmg_pkg::*;

    localparam int LATENCY_CYCLES = 200;   // generous bound on one taken word
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word moving on either side
    localparam int PHASE_ITEMS = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    out_word_t   out_data;

    windowed_stddev_motion_gate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .out_data  (out_data)
    );

    // free-running clock, 10 ns period
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---------------------------------------------------------------------
    // gate predictor: own copy of registers and window state
    // ---------------------------------------------------------------------
    logic [15:0] thr_stddev;
    logic [15:0] thr_p2p;
    logic [15:0] dly_on;
    logic [15:0] dly_off;
    logic [15:0] tol_gap;

    logic [15:0] ring [WINDOW_SAMPLES];
    int unsigned ring_fill;
    int unsigned ring_wr;
    logic        gate_st;
    logic [31:0] motion_t0;
    logic        motion_armed;
    logic [31:0] still_t0;
    logic        still_armed;
    logic [15:0] last_stddev;
    logic [15:0] last_p2p;

    out_word_t   pending_results[$];   // expected output words, oldest first

    int unsigned fail_count;
    int unsigned words_in;
    int unsigned words_out;
    int unsigned gates_seen;          // results with the gate on
    int unsigned motion_seen;         // results with motion in the window

    // window emptied, timers and gate dropped; registers untouched
    function automatic void clear_gate_state();
        ring_fill    = 0;
        ring_wr      = 0;
        gate_st      = 1'b0;
        motion_t0    = '0;
        motion_armed = 1'b0;
        still_t0     = '0;
        still_armed  = 1'b0;
        last_stddev  = '0;
        last_p2p     = '0;
    endfunction

    // advances the predicted state by one word and returns the expected output
    function automatic out_word_t predict_gate(in_word_t w);
        out_word_t      r;
        logic           moving;
        int unsigned    n_ok;
        int unsigned    hi;
        int unsigned    lo;
        int unsigned    mean;
        longint unsigned total;
        longint unsigned sq;
        longint unsigned d;
        longint unsigned var_q;
        longint unsigned root;
        longint unsigned trial;
        r      = '0;
        moving = 1'b0;
        if (w.cmd == CMD_CLEAR) begin
            clear_gate_state();
        end else if (w.sample_g >= ACCEPT_LOW && w.sample_g <= ACCEPT_HIGH) begin
            r.sample_taken = 1'b1;
            ring[ring_wr] = w.sample_g;
            ring_wr = (ring_wr + 1 >= WINDOW_SAMPLES) ? 0 : ring_wr + 1;
            if (ring_fill < WINDOW_SAMPLES)
                ring_fill++;
            // metrics only once enough entries are held and enough are in range
            if (ring_fill >= 6) begin
                n_ok  = 0;
                hi    = 0;
                lo    = 32'hFFFF;
                total = 0;
                for (int i = 0; i < ring_fill; i++) begin
                    if (ring[i] >= VALID_LOW && ring[i] <= VALID_HIGH) begin
                        total += ring[i];
                        n_ok++;
                        if (ring[i] > hi) hi = ring[i];
                        if (ring[i] < lo) lo = ring[i];
                    end
                end
                if (n_ok >= 5) begin
                    mean = int'(total / n_ok);
                    sq   = 0;
                    for (int i = 0; i < ring_fill; i++) begin
                        if (ring[i] >= VALID_LOW && ring[i] <= VALID_HIGH) begin
                            d = (ring[i] >= mean) ? ring[i] - mean : mean - ring[i];
                            sq += d * d;
                        end
                    end
                    var_q = sq / n_ok;
                    // floor square root, one result bit at a time from the top
                    root = 0;
                    for (int b = 31; b >= 0; b--) begin
                        trial = root | (64'd1 << b);
                        if (trial * trial <= var_q)
                            root = trial;
                    end
                    last_stddev = root[15:0];
                    last_p2p    = 16'(hi - lo);
                    moving = (last_stddev >= thr_stddev) && (last_p2p >= thr_p2p);
                end
            end
            // hysteresis on wrapping millisecond differences
            if (moving) begin
                still_armed = 1'b0;
                if (!motion_armed) begin
                    motion_t0    = w.timestamp_ms;
                    motion_armed = 1'b1;
                end
                if (!gate_st && (w.timestamp_ms - motion_t0) >= {16'd0, dly_on})
                    gate_st = 1'b1;
            end else begin
                if (!still_armed) begin
                    still_t0    = w.timestamp_ms;
                    still_armed = 1'b1;
                end
                if (!gate_st && (w.timestamp_ms - still_t0) >= {16'd0, tol_gap})
                    motion_armed = 1'b0;
                if (gate_st && (w.timestamp_ms - still_t0) >= {16'd0, dly_off}) begin
                    gate_st      = 1'b0;
                    motion_armed = 1'b0;
                end
            end
        end
        r.gate_on    = gate_st;
        r.motion_now = moving;
        r.stddev_g   = last_stddev;
        r.p2p_g      = last_p2p;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // receiver side, scoreboard and watchdog
    // ---------------------------------------------------------------------
    int unsigned recv_idle_pct;
    int unsigned recv_hold;      // long hold-off, counted down here
    int unsigned quiet_cycles;

    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            out_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                words_out++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected output word %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    exp_w = pending_results.pop_front();
                    report_field("gate_on", exp_w.gate_on, out_data.gate_on);
                    report_field("motion_now", exp_w.motion_now, out_data.motion_now);
                    report_field("sample_taken", exp_w.sample_taken, out_data.sample_taken);
                    report_field("stddev_g", exp_w.stddev_g, out_data.stddev_g);
                    report_field("p2p_g", exp_w.p2p_g, out_data.p2p_g);
                    if (exp_w.gate_on) gates_seen++;
                    if (exp_w.motion_now) motion_seen++;
                end
            end
            // watchdog: nothing moving on either side for too long
            if ((out_valid && out_ready) || (in_valid && in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t timeout: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------------
    int unsigned send_idle_pct;

    // offers one word from the next falling edge until it is taken
    task automatic send_word(in_word_t w, logic use_typed, out_word_t typed_exp);
        out_word_t predicted;
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_gate(w);
        pending_results.push_back(use_typed ? typed_exp : predicted);
        words_in++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // one register write: setup then access
    task automatic apb_write(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {16'd0, val};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_STDDEV_THR: thr_stddev = val;
            REG_P2P_THR:    thr_p2p    = val;
            REG_ON_DELAY:   dly_on     = val;
            REG_OFF_DELAY:  dly_off    = val;
            REG_GAP_TOL:    tol_gap    = val;
            default: ;
        endcase
    endtask

    // block must be idle before registers move
    task automatic wait_drained();
        drop_valid();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_all_regs(logic [15:0] sd, logic [15:0] pp, logic [15:0] on_d,
                                  logic [15:0] off_d, logic [15:0] gap);
        apb_write(REG_STDDEV_THR, sd);
        apb_write(REG_P2P_THR, pp);
        apb_write(REG_ON_DELAY, on_d);
        apb_write(REG_OFF_DELAY, off_d);
        apb_write(REG_GAP_TOL, gap);
    endtask

    // ---------------------------------------------------------------------
    // random bursts: still, moving, out-of-band and noise segments
    // ---------------------------------------------------------------------
    logic [31:0] clock_ms;
    int unsigned burst_left;
    int unsigned burst_kind;

    function automatic in_word_t next_random_word();
        in_word_t w;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(5, 40);
            burst_kind = $urandom_range(9);
            if ($urandom_range(19) == 0)
                clock_ms = $urandom();          // jump anywhere, wrap included
        end
        burst_left--;
        clock_ms += ($urandom_range(29) == 0) ? $urandom_range(300, 3000) : $urandom_range(1, 40);
        w.cmd          = CMD_SAMPLE;
        w.timestamp_ms = clock_ms;
        if (burst_kind <= 3)
            w.sample_g = 16'd4096 + 16'($urandom_range(0, 60)) - 16'd30;
        else if (burst_kind <= 7)
            w.sample_g = 16'($urandom_range(820, 20479));
        else if (burst_kind == 8)
            w.sample_g = 16'($urandom_range(20480, 32768));
        else
            w.sample_g = 16'($urandom());
        if ($urandom_range(99) == 0)
        begin
            w.cmd      = CMD_CLEAR;
            w.sample_g = 16'($urandom());
            w.timestamp_ms = $urandom();
        end
        return w;
    endfunction

    // ---------------------------------------------------------------------
    // directed table: extremes, both commands, acceptance and validity edges
    // ---------------------------------------------------------------------
    typedef struct {
        logic        cmd;
        logic [15:0] smp;
        logic [31:0] ts;
        logic        typed;
        out_word_t   exp_w;
    } dir_row_t;

    localparam out_word_t ZERO_W  = '0;
    localparam out_word_t TAKEN_W = '{gate_on: 1'b0, motion_now: 1'b0, sample_taken: 1'b1,
                                      stddev_g: 16'd0, p2p_g: 16'd0};

    dir_row_t dir_rows[] = '{
        '{CMD_SAMPLE, 16'd0,     32'd0,          1'b1, ZERO_W},   // below acceptance
        '{CMD_SAMPLE, 16'hFFFF,  32'hFFFF_FFFF,  1'b1, ZERO_W},   // all ones
        '{CMD_SAMPLE, 16'd819,   32'd1,          1'b1, ZERO_W},   // just under 0.20 g
        '{CMD_SAMPLE, 16'd32769, 32'd2,          1'b1, ZERO_W},   // just over 8.0 g
        '{CMD_SAMPLE, 16'd820,   32'd10,         1'b1, TAKEN_W},  // lowest accepted
        '{CMD_SAMPLE, 16'd32768, 32'd20,         1'b1, TAKEN_W},  // highest accepted, not valid
        '{CMD_SAMPLE, 16'd20479, 32'd30,         1'b1, TAKEN_W},  // highest valid
        '{CMD_SAMPLE, 16'd20480, 32'd40,         1'b1, TAKEN_W},  // just above valid
        '{CMD_SAMPLE, 16'd4096,  32'd50,         1'b1, TAKEN_W},
        '{CMD_SAMPLE, 16'd8192,  32'd60,         1'b0, ZERO_W},   // six held, too few valid
        '{CMD_SAMPLE, 16'd12000, 32'd110,        1'b0, ZERO_W},
        '{CMD_SAMPLE, 16'd1000,  32'd160,        1'b0, ZERO_W},
        '{CMD_SAMPLE, 16'd16000, 32'd210,        1'b0, ZERO_W},
        '{CMD_SAMPLE, 16'd2000,  32'd260,        1'b0, ZERO_W},
        '{CMD_SAMPLE, 16'd18000, 32'd310,        1'b0, ZERO_W},
        '{CMD_SAMPLE, 16'd3000,  32'd360,        1'b0, ZERO_W},
        '{CMD_SAMPLE, 16'd65535, 32'd370,        1'b0, ZERO_W},   // rejected with gate held
        '{CMD_SAMPLE, 16'd4096,  32'd400,        1'b0, ZERO_W},
        '{CMD_SAMPLE, 16'd4096,  32'd2000,       1'b0, ZERO_W},   // long gap in time
        '{CMD_CLEAR,  16'hFFFF,  32'hFFFF_FFFF,  1'b1, ZERO_W},   // clear ignores fields
        '{CMD_CLEAR,  16'd0,     32'd0,          1'b1, ZERO_W},
        '{CMD_SAMPLE, 16'd4096,  32'hFFFF_FFF0,  1'b1, TAKEN_W}   // near the wrap
    };

    initial
    begin
        in_word_t w;
        fail_count    = 0;
        words_in      = 0;
        words_out     = 0;
        gates_seen    = 0;
        motion_seen   = 0;
        quiet_cycles  = 0;
        recv_hold     = 0;
        burst_left    = 0;
        burst_kind    = 0;
        clock_ms      = 32'hFFFF_F000;
        send_idle_pct = 38;
        recv_idle_pct = 85;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        thr_stddev = 16'd225;
        thr_p2p    = 16'd492;
        dly_on     = 16'd180;
        dly_off    = 16'd1200;
        tol_gap    = 16'd100;
        clear_gate_state();

        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset register values
        foreach (dir_rows[i])
        begin
            w.cmd          = dir_rows[i].cmd;
            w.sample_g     = dir_rows[i].smp;
            w.timestamp_ms = dir_rows[i].ts;
            send_word(w, dir_rows[i].typed, dir_rows[i].exp_w);
        end

        // random phases, each under its own register setting and idling mix
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            case (ph)
                0: write_all_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                1: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: write_all_regs(16'd225, 16'd492, 16'd180, 16'd1200, 16'd100);
                3: write_all_regs(16'($urandom_range(50, 2000)), 16'($urandom_range(100, 6000)),
                                  16'($urandom_range(0, 400)), 16'($urandom_range(0, 2000)),
                                  16'($urandom_range(0, 300)));
                4: write_all_regs(16'd20, 16'd50, 16'd1, 16'd60, 16'd65535);
                default: write_all_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                                        16'($urandom()), 16'($urandom()));
            endcase
            // sender 38 / receiver 85, then swapped, then no idling
            send_idle_pct = (ph < 2) ? 38 : (ph < 4) ? 85 : 0;
            recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 38 : 0;
            if (ph == 4)
                recv_hold = 400;     // back up the block while words keep coming
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                w = next_random_word();
                send_word(w, 1'b0, ZERO_W);
            end
        end

        wait_drained();
        $display("run covered %0d words in, %0d out, over six register settings",
                 words_in, words_out);
        $display("results with motion seen: %0d, with gate on: %0d", motion_seen, gates_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
